// ===== src/pgc_pkg.sv =====
package pgc_pkg;

  typedef enum logic [1:0] {
    OP_KIND = 2'd0,
    OP_EDGE = 2'd1,
    OP_PATH = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [9:0] COST_PLAIN  = 10'd10;
  localparam logic [9:0] COST_BYPASS = 10'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] node;
    logic [5:0] target_node;
    logic       is_bypass;
    logic       last_in_path;
  } cmd_t;

endpackage

// ===== src/path_gap_completion.sv =====
// Path gap completion. Load words (operation 0: set node kind, 1: add edge)
// build a directed graph; path words (operation 2) are echoed in order, and
// when an element is not adjacent to its predecessor a Dijkstra search first
// emits the cheapest intermediate nodes with filled_in set. A repeated element
// that is not adjacent to itself is dropped unless it is last_in_path. A gap
// search runs a setup step, then for each settled node a pipelined minimum
// scan, a row fetch and a relax sweep, then a final scan, a backtrack over the
// parents and the emission of the stored nodes. The engine takes the next word
// only after its last result word has been accepted. A two-entry queue sits
// between the input and the search engine.
module path_gap_completion
  import pgc_pkg::*;
#(
  parameter int NODES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [5:0] node,
  input  logic [5:0] target_node,
  input  logic       is_bypass,
  input  logic       last_in_path,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] element,
  output logic       filled_in,
  output logic       path_end
);

  cmd_t in_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_ready;

  assign in_cmd = '{operation: operation, node: node, target_node: target_node,
                    is_bypass: is_bypass, last_in_path: last_in_path};

  pgc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd  (in_cmd),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd)
  );

  pgc_back #(.NODES(NODES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .element  (element),
    .filled_in(filled_in),
    .path_end (path_end)
  );

`ifndef SYNTHESIS
  a_fill_not_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && filled_in |-> !path_end)
    else $error("filled word marked as path end");

  a_queue_hand: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |=> !out_valid || $stable(element) || !$past(out_valid))
    else $error("result changed while engine took a word");

  a_out_after_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid out of reset");
`endif

endmodule

// ===== src/pgc_front.sv =====
module pgc_front
  import pgc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cmd_t       in_cmd,
  output logic       q_valid,
  input  logic       q_ready,
  output cmd_t       q_cmd
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_valid && q_ready) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
    end
  end

endmodule

// ===== src/pgc_back.sv =====
module pgc_back
  import pgc_pkg::*;
#(
  parameter int NODES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_ready,
  input  cmd_t       q_cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] element,
  output logic       filled_in,
  output logic       path_end
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EDGE  = 10'b0000000010,
    S_CHECK = 10'b0000000100,
    S_INIT  = 10'b0000001000,
    S_SCAN  = 10'b0000010000,
    S_ROW   = 10'b0000100000,
    S_RELAX = 10'b0001000000,
    S_BACK  = 10'b0010000000,
    S_EMIT  = 10'b0100000000,
    S_FINAL = 10'b1000000000
  } state_t;

  state_t      state;
  logic [63:0] adj [64];
  logic [63:0] adj_q;
  logic [63:0] row_ok;
  logic [63:0] bypass;
  logic [63:0] reached;
  logic [63:0] settled;
  logic [9:0]  cost [64];
  logic [9:0]  cost_q;
  logic [5:0]  parent [64];
  logic [5:0]  par_q;
  logic [5:0]  stack [64];
  logic [5:0]  stack_q;
  logic [6:0]  idx;
  logic [5:0]  pipe_i;
  logic        pipe_v;
  logic        phase;
  logic [5:0]  best;
  logic [9:0]  bestd;
  logic        have_best;
  logic [6:0]  depth;
  logic [5:0]  curr;
  logic [5:0]  prev;
  logic        have_prev;
  cmd_t        cur;
  logic [5:0]  src;

  logic        valid_reg;
  logic [5:0]  elem_reg;
  logic        fill_reg;
  logic        end_reg;

  logic [5:0]  i6;
  logic [5:0]  adj_addr;
  logic [9:0]  nd;
  logic        idle_take;
  logic        in_range;
  logic        tgt_range;
  logic        edge_pn;
  logic        scan_hit;
  logic        row_hit;
  logic        relax_upd;
  logic        back_step;
  logic        emit_go;
  logic        final_go;

  assign i6        = idx[5:0];
  assign idle_take = q_valid && q_ready;
  assign in_range  = (32'(q_cmd.node) < NODES);
  assign tgt_range = (32'(q_cmd.target_node) < NODES);
  assign adj_addr  = (state != S_IDLE) ? best :
                     (q_cmd.operation == OP_EDGE) ? q_cmd.node : prev;
  assign edge_pn   = (32'(prev) < NODES) && (32'(cur.node) < NODES) && row_ok[prev]
                     && adj_q[cur.node];
  assign nd        = bestd + (bypass[pipe_i] ? COST_BYPASS : COST_PLAIN);
  assign scan_hit  = pipe_v && reached[pipe_i] && !settled[pipe_i]
                     && (!have_best || cost_q < bestd);
  assign row_hit   = pipe_v && row_ok[best] && adj_q[pipe_i];
  assign relax_upd = (state == S_RELAX) && row_hit && (!reached[pipe_i] || cost_q > nd);
  assign back_step = (state == S_BACK) && phase && (par_q != curr) && (depth < 7'd64);
  assign emit_go   = (state == S_EMIT) && (depth > 7'd1) && phase && !valid_reg;
  assign final_go  = (state == S_FINAL) && !valid_reg;

  assign q_ready   = (state == S_IDLE) && !valid_reg;
  assign out_valid = valid_reg;
  assign element   = elem_reg;
  assign filled_in = fill_reg;
  assign path_end  = end_reg;

  always_ff @(posedge clk) begin
    adj_q   <= adj[adj_addr];
    cost_q  <= cost[i6];
    par_q   <= parent[curr];
    stack_q <= stack[6'(depth - 7'd2)];
    if (state == S_EDGE) begin
      adj[cur.node] <= (row_ok[cur.node] ? adj_q : 64'd0) | (64'd1 << cur.target_node);
    end
    if (state == S_INIT) begin
      cost[src]   <= 10'd0;
      parent[src] <= src;
    end
    if (relax_upd) begin
      cost[pipe_i]   <= nd;
      parent[pipe_i] <= best;
    end
    if (back_step) begin
      stack[depth[5:0]] <= par_q;
    end
    if (emit_go) begin
      elem_reg <= stack_q;
    end
    if (final_go) begin
      elem_reg <= cur.node;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_ok    <= '0;
      bypass    <= '0;
      reached   <= '0;
      settled   <= '0;
      have_prev <= 1'b0;
      prev      <= 6'd0;
      valid_reg <= 1'b0;
      fill_reg  <= 1'b0;
      end_reg   <= 1'b0;
      idx       <= '0;
      pipe_i    <= '0;
      pipe_v    <= 1'b0;
      phase     <= 1'b0;
      depth     <= '0;
      have_best <= 1'b0;
      best      <= '0;
      bestd     <= '0;
      curr      <= '0;
      src       <= '0;
      cur       <= '0;
    end else begin
      if (valid_reg && out_ready) begin
        valid_reg <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (idle_take) begin
            cur <= q_cmd;
            case (q_cmd.operation)
              OP_KIND: begin
                if (in_range) begin
                  bypass[q_cmd.node] <= q_cmd.is_bypass;
                end
              end
              OP_EDGE: begin
                if (in_range && tgt_range) begin
                  state <= S_EDGE;
                end
              end
              OP_PATH: begin
                state <= S_CHECK;
              end
              default: begin
              end
            endcase
          end
        end
        S_EDGE: begin
          row_ok[cur.node] <= 1'b1;
          state            <= S_IDLE;
        end
        S_CHECK: begin
          if (have_prev && !edge_pn && prev == cur.node) begin
            if (cur.last_in_path) begin
              state <= S_FINAL;
            end else begin
              state <= S_IDLE;
            end
          end else if (have_prev && !edge_pn && 32'(prev) < NODES
                       && 32'(cur.node) < NODES) begin
            src   <= prev;
            state <= S_INIT;
          end else begin
            state <= S_FINAL;
          end
        end
        S_INIT: begin
          reached   <= 64'd1 << src;
          settled   <= '0;
          idx       <= '0;
          pipe_v    <= 1'b0;
          have_best <= 1'b0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          if (32'(idx) < NODES) begin
            idx    <= idx + 7'd1;
            pipe_i <= i6;
            pipe_v <= 1'b1;
          end else begin
            pipe_v <= 1'b0;
          end
          if (scan_hit) begin
            have_best <= 1'b1;
            best      <= pipe_i;
            bestd     <= cost_q;
          end
          if (32'(idx) >= NODES && !pipe_v) begin
            if (!have_best) begin
              state <= S_FINAL;
            end else begin
              settled[best] <= 1'b1;
              if (best == cur.node) begin
                curr  <= cur.node;
                depth <= '0;
                phase <= 1'b0;
                state <= S_BACK;
              end else begin
                state <= S_ROW;
              end
            end
          end
        end
        S_ROW: begin
          idx   <= '0;
          state <= S_RELAX;
        end
        S_RELAX: begin
          if (32'(idx) < NODES) begin
            idx    <= idx + 7'd1;
            pipe_i <= i6;
            pipe_v <= 1'b1;
          end else begin
            pipe_v <= 1'b0;
          end
          if (row_hit) begin
            reached[pipe_i] <= 1'b1;
          end
          if (32'(idx) >= NODES && !pipe_v) begin
            idx       <= '0;
            have_best <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_BACK: begin
          if (!phase) begin
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (par_q != curr && depth < 7'd64) begin
              curr  <= par_q;
              depth <= depth + 7'd1;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (depth <= 7'd1) begin
            state <= S_FINAL;
          end else if (!phase) begin
            phase <= 1'b1;
          end else if (!valid_reg) begin
            valid_reg <= 1'b1;
            fill_reg  <= 1'b1;
            end_reg   <= 1'b0;
            depth     <= depth - 7'd1;
            phase     <= 1'b0;
          end
        end
        S_FINAL: begin
          if (!valid_reg) begin
            valid_reg <= 1'b1;
            fill_reg  <= 1'b0;
            end_reg   <= cur.last_in_path;
            prev      <= cur.node;
            have_prev <= !cur.last_in_path;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
